// ----- rtl/core/joint_jog_rate_smoother_unit_macros.svh -----
// assertion macros for the joint jog rate smoother
// expects clk_i and rst_ni in the scope of use
`ifndef JOINT_JOG_RATE_SMOOTHER_UNIT_MACROS_SVH
`define JOINT_JOG_RATE_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication
`define JJRS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JJRS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/jjrs_pkg.sv -----
// joint jog rate smoother package: word types, command struct, constants
// and the rounding and saturation helpers; no dependencies
package jjrs_pkg;

  localparam int unsigned NUM_AXES = 6;
  localparam int unsigned RAW_W    = 10;
  localparam int unsigned K_W      = 33;
  localparam int unsigned PROD_W   = RAW_W + K_W + 1;
  localparam int unsigned J5_W     = PROD_W + 17;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned FILT_W   = DIFF_W + 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic signed [7:0]       DEAD_BAND        = 8'sd10;
  localparam logic signed [16:0]      SEVEN_TENTHS_Q16 = 17'sd45875;
  localparam logic signed [RAW_W-1:0] BUMPER_SCALE     = 10'sd100;
  localparam logic [16:0]             ONE_Q16          = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 2'd2;

  localparam logic [2:0] LOCK_ALL = 3'd0;

  localparam logic [23:0] SENS_RESET   = 24'd65536;
  localparam logic [23:0] LIMIT_RESET  = 24'd65536;
  localparam logic [16:0] SMOOTH_RESET = 17'd6554;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic [6:0]        left_trigger;
    logic [6:0]        right_trigger;
    logic              left_bumper;
    logic              right_bumper;
    logic [2:0]        lock_select;
  } jjrs_in_t;

  typedef struct packed {
    logic signed [31:0] joint1_rate;
    logic signed [31:0] joint2_rate;
    logic signed [31:0] joint3_rate;
    logic signed [31:0] joint4_rate;
    logic signed [31:0] joint5_rate;
    logic signed [31:0] joint6_rate;
  } jjrs_out_t;

  typedef struct packed {
    logic capture;
    logic k_load;
    logic tgt_load;
    logic j5_load;
    logic clamp_load;
    logic flt_load;
    logic upd_load;
  } jjrs_cmd_t;

  // shift right by 16, nearest, ties away from zero
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] b;
    b = x + (x[63] ? 64'sd32767 : 64'sd32768);
    return b >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/jjrs_in_if.sv -----
// gamepad sample channel: valid, ready and the sample word
// depends on jjrs_pkg
interface jjrs_in_if import jjrs_pkg::*; ();
  logic     valid;
  logic     ready;
  jjrs_in_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/core/jjrs_out_if.sv -----
// joint rate channel: valid, ready and the six-rate word
// depends on jjrs_pkg
interface jjrs_out_if import jjrs_pkg::*; ();
  logic      valid;
  logic      ready;
  jjrs_out_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/core/joint_jog_rate_smoother_unit.sv -----
// a sample word is accepted only in idle; the sequencer then steps gain,
// target, 0.7 scale, clamp, filter and update through shared lane registers,
// and no new sample is taken until the update step is done
// the update step waits while an earlier result word is still unread
// reset: filter states cleared, config back to defaults, no word pending
// depends on jjrs_pkg, jjrs_in_if, jjrs_out_if, jjrs_ctrl, jjrs_dp and the macros
`include "joint_jog_rate_smoother_unit_macros.svh"

module joint_jog_rate_smoother_unit import jjrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jjrs_in_if.sink               in_if,
  jjrs_out_if.source            out_if
);

  jjrs_cmd_t cmd;

  jjrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .out_ready_i (out_if.ready),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  jjrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .in_word_i   (in_if.word),
    .out_word_o  (out_if.word)
  );

  `JJRS_ASSERT_NXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready, "ready after accept")
  `JJRS_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "overlapping commands")
  `JJRS_ASSERT_IMP(a_no_overwrite, cmd.upd_load, !out_if.valid || out_if.ready, "result overwritten")
  `JJRS_ASSERT_IMP(a_valid_from_update, $rose(out_if.valid), $past(cmd.upd_load), "stray valid")

endmodule

// ----- rtl/core/jjrs_ctrl.sv -----
// sequencer for the smoother: steps one sample through gain, target, scale,
// clamp, filter and update, and owns the result valid flag; uses jjrs_pkg
module jjrs_ctrl import jjrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output jjrs_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_KGAIN  = 3'd1;
  localparam logic [2:0] ST_TARGET = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_CLAMP  = 3'd4;
  localparam logic [2:0] ST_FILTER = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy;

  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_busy;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_KGAIN;
        end
      end
      ST_KGAIN: begin
        cmd_o.k_load = 1'b1;
        state_d      = ST_TARGET;
      end
      ST_TARGET: begin
        cmd_o.tgt_load = 1'b1;
        state_d        = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.j5_load = 1'b1;
        state_d       = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp_load = 1'b1;
        state_d          = ST_FILTER;
      end
      ST_FILTER: begin
        cmd_o.flt_load = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_busy) begin
          cmd_o.upd_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/jjrs_dp.sv -----
// datapath for the smoother: config registers, six filter lanes,
// filter state and the result word register; uses jjrs_pkg
module jjrs_dp import jjrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  jjrs_cmd_t             cmd_i,
  input  jjrs_in_t              in_word_i,
  output jjrs_out_t             out_word_o
);

  logic [23:0] sens_q;
  logic [23:0] limit_q;
  logic [16:0] smooth_q;

  logic signed [7:0] lx_q, ly_q, rx_q, ry_q;
  logic [6:0]        lt_q, rt_q;
  logic              lb_q, rb_q;
  logic [2:0]        lock_q;

  logic [K_W-1:0]            k_q;
  logic signed [PROD_W-1:0]  prod_q [NUM_AXES];
  logic signed [J5_W-1:0]    j5_q;
  logic signed [31:0]        tgt_q  [NUM_AXES];
  logic signed [FILT_W-1:0]  filt_q [NUM_AXES];
  logic signed [31:0]        s_q    [NUM_AXES];
  logic signed [31:0]        s_d    [NUM_AXES];
  jjrs_out_t                 out_q;

  logic signed [RAW_W-1:0]   raw   [NUM_AXES];
  logic [47:0]               kprod;
  logic [48:0]               kround;
  logic [16:0]               a_eff;
  logic signed [DIFF_W-1:0]  diff  [NUM_AXES];
  logic signed [31:0]        pass_rate [NUM_AXES];

  function automatic logic signed [7:0] dead(input logic signed [7:0] v);
    return ((v > DEAD_BAND) || (v < -DEAD_BAND)) ? v : 8'sd0;
  endfunction

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q   <= SENS_RESET;
      limit_q  <= LIMIT_RESET;
      smooth_q <= SMOOTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSITIVITY: sens_q   <= cfg_wdata_i;
        CFG_RATE_LIMIT:  limit_q  <= cfg_wdata_i;
        CFG_SMOOTHING:   smooth_q <= cfg_wdata_i[16:0];
        default: begin
        end
      endcase
    end
  end

  // lane operands
  assign kprod  = 48'(sens_q) * 48'(limit_q);
  assign kround = {1'b0, kprod} + 49'd32768;
  assign a_eff  = smooth_q[16] ? ONE_Q16 : smooth_q;

  always_comb begin
    raw[0] = -RAW_W'(lx_q);
    raw[1] = RAW_W'(ly_q);
    raw[2] = $signed({3'b000, lt_q}) - $signed({3'b000, rt_q});
    raw[3] = RAW_W'(rx_q);
    raw[4] = RAW_W'(ry_q);
    if (rb_q && !lb_q) begin
      raw[5] = BUMPER_SCALE;
    end else if (lb_q && !rb_q) begin
      raw[5] = -BUMPER_SCALE;
    end else begin
      raw[5] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] = DIFF_W'(tgt_q[i]) - DIFF_W'(s_q[i]);
      s_d[i]  = sat32(64'(s_q[i]) + rnd16(64'(filt_q[i])));
      pass_rate[i] = ((lock_q == LOCK_ALL) || (lock_q == 3'(i + 1))) ? s_d[i] : 32'sd0;
    end
  end

  // sample capture and lane pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lx_q   <= dead(in_word_i.left_x);
      ly_q   <= dead(in_word_i.left_y);
      rx_q   <= dead(in_word_i.right_x);
      ry_q   <= dead(in_word_i.right_y);
      lt_q   <= in_word_i.left_trigger;
      rt_q   <= in_word_i.right_trigger;
      lb_q   <= in_word_i.left_bumper;
      rb_q   <= in_word_i.right_bumper;
      lock_q <= in_word_i.lock_select;
    end
    if (cmd_i.k_load) begin
      k_q <= kround[48:16];
    end
    if (cmd_i.tgt_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prod_q[i] <= PROD_W'(raw[i]) * PROD_W'($signed({1'b0, k_q}));
      end
    end
    if (cmd_i.j5_load) begin
      j5_q <= J5_W'(prod_q[4]) * J5_W'(SEVEN_TENTHS_Q16);
    end
    if (cmd_i.clamp_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (i == 4) begin
          tgt_q[i] <= sat32(rnd16(64'(j5_q)));
        end else begin
          tgt_q[i] <= sat32(64'(prod_q[i]));
        end
      end
    end
    if (cmd_i.flt_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        filt_q[i] <= FILT_W'($signed({1'b0, a_eff})) * FILT_W'(diff[i]);
      end
    end
    if (cmd_i.upd_load) begin
      out_q.joint1_rate <= pass_rate[0];
      out_q.joint2_rate <= pass_rate[1];
      out_q.joint3_rate <= pass_rate[2];
      out_q.joint4_rate <= pass_rate[3];
      out_q.joint5_rate <= pass_rate[4];
      out_q.joint6_rate <= pass_rate[5];
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s_q[i] <= '0;
      end
    end else if (cmd_i.upd_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s_q[i] <= s_d[i];
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ----- dv/jjrs_rate_checker.sv -----
// scoreboard for the joint jog rate smoother: follows the config port and both
// channels, predicts each rate word and compares it lane by lane
// depends on jjrs_pkg, jjrs_in_if and jjrs_out_if
module jjrs_rate_checker
  import jjrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jjrs_in_if                    sample_mon,
  jjrs_out_if                   rate_mon,
  output int unsigned           mismatch_count,
  output int unsigned           words_pending
);

  localparam longint STICK_DEADZONE = 10;
  localparam longint SEVEN_TENTHS   = 45875;
  localparam longint BUMPER_GAIN    = 100;
  localparam longint UNITY_Q16      = 65536;
  localparam longint HALF_LSB       = 32768;
  localparam longint I32_MAX        = 64'sd2147483647;
  localparam longint I32_MIN        = -64'sd2147483648;

  logic [23:0] gain_sens;
  logic [23:0] gain_limit;
  logic [16:0] alpha_q16;
  int          filt_state [NUM_AXES];
  jjrs_out_t   expected_rates [$];

  // nearest, ties away from zero
  function automatic longint shift_round(input longint x);
    if (x >= 0) return (x + HALF_LSB) >>> 16;
    return -((-x + HALF_LSB) >>> 16);
  endfunction

  function automatic int clip32(input longint x);
    if (x > I32_MAX) return 32'sh7fffffff;
    if (x < I32_MIN) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic longint stick_level(input logic signed [7:0] v);
    longint w;
    w = v;
    return (w > STICK_DEADZONE || w < -STICK_DEADZONE) ? w : 64'sd0;
  endfunction

  function automatic jjrs_out_t advance_joint_filters(input jjrs_in_t s);
    longint    gain;
    longint    alpha;
    longint    lx, ly, rx, ry, trig, bump, d;
    int        target [NUM_AXES];
    int        lane [NUM_AXES];
    jjrs_out_t r;
    gain  = (longint'(gain_sens) * longint'(gain_limit) + HALF_LSB) >>> 16;
    alpha = (alpha_q16 > UNITY_Q16) ? UNITY_Q16 : longint'(alpha_q16);
    lx    = stick_level(s.left_x);
    ly    = stick_level(s.left_y);
    rx    = stick_level(s.right_x);
    ry    = stick_level(s.right_y);
    trig  = longint'(s.left_trigger) - longint'(s.right_trigger);
    bump  = longint'(s.right_bumper) - longint'(s.left_bumper);
    target[0] = clip32(-lx * gain);
    target[1] = clip32(ly * gain);
    target[2] = clip32(trig * gain);
    target[3] = clip32(rx * gain);
    target[4] = clip32(shift_round(ry * gain * SEVEN_TENTHS));
    target[5] = clip32(bump * BUMPER_GAIN * gain);
    for (int i = 0; i < NUM_AXES; i++) begin
      d = longint'(target[i]) - longint'(filt_state[i]);
      filt_state[i] = clip32(longint'(filt_state[i]) + shift_round(alpha * d));
      lane[i] = (s.lock_select == LOCK_ALL || s.lock_select == i + 1) ? filt_state[i] : 0;
    end
    r.joint1_rate = lane[0];
    r.joint2_rate = lane[1];
    r.joint3_rate = lane[2];
    r.joint4_rate = lane[3];
    r.joint5_rate = lane[4];
    r.joint6_rate = lane[5];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : tracker
    jjrs_out_t          want;
    jjrs_out_t          got;
    logic signed [31:0] want_l;
    logic signed [31:0] got_l;
    if (!rst_ni) begin
      gain_sens  = 24'd65536;
      gain_limit = 24'd65536;
      alpha_q16  = 17'd6554;
      for (int i = 0; i < NUM_AXES; i++) filt_state[i] = 0;
      expected_rates.delete();
      mismatch_count = 0;
      words_pending  = 0;
    end else begin
      if (rate_mon.valid && rate_mon.ready) begin
        got = rate_mon.word;
        if (expected_rates.size() == 0) begin
          $error("rate word with nothing expected: %h", got);
          mismatch_count++;
        end else begin
          want = expected_rates.pop_front();
          for (int i = 0; i < NUM_AXES; i++) begin
            want_l = want[(NUM_AXES - 1 - i) * 32 +: 32];
            got_l  = got[(NUM_AXES - 1 - i) * 32 +: 32];
            if (want_l !== got_l) begin
              $error("joint%0d_rate: expected %0d, actual %0d", i + 1, want_l, got_l);
              mismatch_count++;
            end
          end
        end
      end
      if (sample_mon.valid && sample_mon.ready) begin
        expected_rates.push_back(advance_joint_filters(sample_mon.word));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SENSITIVITY: gain_sens  = cfg_wdata_i;
          CFG_RATE_LIMIT:  gain_limit = cfg_wdata_i;
          CFG_SMOOTHING:   alpha_q16  = cfg_wdata_i[16:0];
          default: ;
        endcase
      end
      words_pending = expected_rates.size();
    end
  end

endmodule

// ----- dv/joint_jog_rate_smoother_unit_tb.sv -----
// testbench top for the joint jog rate smoother: clock, reset, config writes,
// gamepad sample stimulus with flow control phases, and the verdict
// depends on jjrs_pkg, jjrs_in_if, jjrs_out_if, jjrs_rate_checker and the block
module joint_jog_rate_smoother_unit_tb;
  import jjrs_pkg::*;

  localparam int unsigned          QUIET_LIMIT  = 2000;
  localparam int unsigned          DRAIN_CYCLES = 10;
  localparam int unsigned          TAIL_CYCLES  = 20;
  localparam int unsigned          PHASES       = 8;
  localparam int unsigned          PHASE_ITEMS  = 86;
  localparam logic [2:0]           LOCK_NONE    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int unsigned           sender_idle_pct;
  int unsigned           sink_stall_pct;
  int unsigned           quiet_cycles;
  int unsigned           mismatch_count;
  int unsigned           words_pending;

  jjrs_in_if  sample_ch ();
  jjrs_out_if rate_ch ();

  joint_jog_rate_smoother_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (sample_ch),
    .out_if      (rate_ch)
  );

  jjrs_rate_checker u_rate_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_mon     (sample_ch),
    .rate_mon       (rate_ch),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rate_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (rate_ch.valid && rate_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL joint_jog_rate_smoother_unit");
      $finish;
    end
  end

  function automatic jjrs_in_t make_sample(input logic signed [7:0] lx, input logic signed [7:0] ly,
                                           input logic signed [7:0] rx, input logic signed [7:0] ry,
                                           input logic [6:0] lt, input logic [6:0] rt,
                                           input logic lb, input logic rb, input logic [2:0] lock);
    jjrs_in_t s;
    s.left_x        = lx;
    s.left_y        = ly;
    s.right_x       = rx;
    s.right_y       = ry;
    s.left_trigger  = lt;
    s.right_trigger = rt;
    s.left_bumper   = lb;
    s.right_bumper  = rb;
    s.lock_select   = lock;
    return s;
  endfunction

  function automatic logic signed [7:0] stick_value();
    int unsigned pick;
    int          v;
    pick = $urandom_range(9);
    if (pick == 0) begin
      v = $urandom_range(12, 9);
      if ($urandom_range(1) == 1) v = -v;
      return 8'(v);
    end
    if (pick == 1) return ($urandom_range(1) == 1) ? 8'sd127 : -8'sd128;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [6:0] trigger_value();
    if ($urandom_range(3) != 0) return ($urandom_range(1) == 1) ? 7'd99 : 7'd0;
    return 7'($urandom_range(127));
  endfunction

  function automatic jjrs_in_t random_sample();
    jjrs_in_t s;
    s.left_x        = stick_value();
    s.left_y        = stick_value();
    s.right_x       = stick_value();
    s.right_y       = stick_value();
    s.left_trigger  = trigger_value();
    s.right_trigger = trigger_value();
    s.left_bumper   = 1'($urandom_range(1));
    s.right_bumper  = 1'($urandom_range(1));
    s.lock_select   = ($urandom_range(1) == 0) ? LOCK_ALL : 3'($urandom_range(7));
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return 24'hffffff;
      2: return 24'd65536;
      default: return 24'($urandom_range(24'h3ffff));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_smoothing();
    case ($urandom_range(5))
      0: return '0;
      1: return 24'd65536;
      2: return 24'($urandom_range(24'hffffff, 65537));
      default: return 24'($urandom_range(65536));
    endcase
  endfunction

  task automatic set_flow(input flow_mode_e mode);
    sender_idle_pct = (mode == FLOW_SENDER_IDLE) ? 80 : (mode == FLOW_BOTH) ? 12 : 0;
    sink_stall_pct  = (mode == FLOW_SINK_STALL) ? 80 : (mode == FLOW_BOTH) ? 12 : 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // called just after a falling edge, returns just after a falling edge once the sample is accepted
  task automatic send_sample(input jjrs_in_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid = 1'b1;
    sample_ch.word  = s;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    sample_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    sample_ch.valid = 1'b0;
    sample_ch.word  = '0;
    rate_ch.ready   = 1'b1;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words at reset settings
    set_flow(FLOW_FREE);
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, LOCK_ALL));
    send_sample(make_sample(-128, 127, 127, -128, 99, 0, 0, 1, LOCK_ALL));
    send_sample(make_sample(127, -128, -128, 127, 0, 99, 1, 0, LOCK_ALL));
    send_sample(make_sample(10, -10, 10, -10, 0, 0, 0, 0, LOCK_ALL));
    send_sample(make_sample(11, -11, -11, 11, 0, 0, 0, 0, LOCK_ALL));
    send_sample(make_sample(-10, 10, -9, 9, 0, 0, 0, 0, LOCK_ALL));
    send_sample(make_sample(0, 0, 0, 0, 127, 0, 0, 0, LOCK_ALL));
    send_sample(make_sample(0, 0, 0, 0, 100, 127, 1, 1, LOCK_ALL));
    for (int lock = 1; lock <= 7; lock++) begin
      send_sample(make_sample(-100, 90, -80, 70, 99, 0, 0, 1, 3'(lock)));
    end
    drain();

    // largest gains and smoothing above one, upper data bits set
    write_reg(CFG_SENSITIVITY, 24'hffffff);
    write_reg(CFG_RATE_LIMIT, 24'hffffff);
    write_reg(CFG_SMOOTHING, 24'hffffff);
    send_sample(make_sample(-128, 127, 127, -128, 0, 127, 0, 1, LOCK_ALL));
    send_sample(make_sample(127, -128, -128, 127, 127, 0, 1, 0, LOCK_ALL));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 1, 1, LOCK_NONE));
    drain();

    // frozen filter, zero gains, ignored index
    write_reg(CFG_SMOOTHING, '0);
    write_reg(CFG_SENSITIVITY, '0);
    write_reg(CFG_RATE_LIMIT, '0);
    write_reg(CFG_UNUSED, 24'ha5a5a5);
    send_sample(make_sample(-128, 127, 127, -128, 99, 0, 0, 1, LOCK_ALL));
    drain();
    write_reg(CFG_SMOOTHING, 24'd65536);
    write_reg(CFG_SENSITIVITY, 24'd65536);
    write_reg(CFG_RATE_LIMIT, 24'd131072);
    send_sample(make_sample(-128, 127, 127, -128, 99, 0, 0, 1, LOCK_ALL));
    send_sample(make_sample(50, -50, 12, -12, 0, 99, 1, 0, LOCK_ALL));
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      write_reg(CFG_SENSITIVITY, pick_gain());
      write_reg(CFG_RATE_LIMIT, pick_gain());
      write_reg(CFG_SMOOTHING, pick_smoothing());
      if ($urandom_range(1) == 1) write_reg(CFG_UNUSED, 24'($urandom));
      set_flow(flow_mode_e'(p % 4));
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain();
    end

    while (words_pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS joint_jog_rate_smoother_unit");
    end else begin
      $display("FAIL joint_jog_rate_smoother_unit");
    end
    $finish;
  end

endmodule

// ----- joint_jog_rate_smoother_unit.f -----
+incdir+rtl/core
rtl/core/jjrs_pkg.sv
rtl/core/jjrs_in_if.sv
rtl/core/jjrs_out_if.sv
rtl/core/jjrs_ctrl.sv
rtl/core/jjrs_dp.sv
rtl/core/joint_jog_rate_smoother_unit.sv
dv/jjrs_rate_checker.sv
dv/joint_jog_rate_smoother_unit_tb.sv
